// ----- sv/rbtd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbtd_pkg
// Shared types and constants for the RTTY bit timing deframer.
// ----------------------------------------------------------------------------
package rbtd_pkg;

	// Field and register widths
	localparam int TICK_W     = 15;
	localparam int ELAPSED_W  = 16;
	localparam int GSUM_W     = ELAPSED_W + 1;
	localparam int CODE_W     = 5;
	localparam int DUR_W      = 32;
	localparam int RUN_W      = DUR_W + 2;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 8;

	// Framing: start bit at the top of the 8-bit window, two stop bits at the bottom
	localparam int FRAME_BITS   = 8;
	localparam int START_BIT    = 7;
	localparam int STOP_BIT_LO  = 0;
	localparam int STOP_BIT_HI  = 1;
	localparam int CODE_LSB     = 2;
	localparam int COUNT_MAX    = 31;
	localparam int MAX_RESULTS  = 3;
	localparam int RES_IDX_W    = 2;
	localparam int MAX_RUN_BITS = 32;
	localparam int RUN_CNT_W    = 6;

	// Configuration register indices
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TICKS = 2'd1;

	localparam logic [TICK_W-1:0] SYMBOL_TICKS_RESET = 15'd1375;
	localparam logic [TICK_W-1:0] SWITCH_TICKS_RESET = 15'd343;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_BITS,
		ST_FRAME,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic bit_step;
		logic frame_step;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic run_more;
		logic frame_more;
		logic have_codes;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

// ----- sv/rbtd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbtd_ctrl
// Sequencer: level update, bit generation, deframing and result delivery.
// ----------------------------------------------------------------------------
module rbtd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  rbtd_pkg::status_t status,
	output rbtd_pkg::cmd_t    cmd
);

	rbtd_pkg::state_t state_q;
	rbtd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbtd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			rbtd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = rbtd_pkg::ST_UPDATE;
				end
			end
			rbtd_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = rbtd_pkg::ST_BITS;
			end
			rbtd_pkg::ST_BITS: begin
				if (status.run_more) begin
					cmd.bit_step = 1'b1;
				end else begin
					state_d = rbtd_pkg::ST_FRAME;
				end
			end
			rbtd_pkg::ST_FRAME: begin
				if (status.frame_more) begin
					cmd.frame_step = 1'b1;
				end else if (status.have_codes) begin
					state_d = rbtd_pkg::ST_EMIT;
				end else begin
					state_d = rbtd_pkg::ST_IDLE;
				end
			end
			rbtd_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_load = 1'b1;
					if (status.emit_last) begin
						state_d = rbtd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rbtd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/rbtd_dp.sv -----
// ----------------------------------------------------------------------------
// rbtd_dp
// Datapath: deglitcher, run durations, bit shifter, frame checker and
// the output register.
// ----------------------------------------------------------------------------
module rbtd_dp #(
	parameter int SHIFT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rbtd_pkg::TICK_W-1:0]         cfg_data,
	input  logic [rbtd_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rbtd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast,
	input  rbtd_pkg::cmd_t                      cmd,
	output rbtd_pkg::status_t                   status
);

	localparam int EXT_W = SHIFT_WIDTH + rbtd_pkg::COUNT_MAX;

	// Configuration
	logic [rbtd_pkg::TICK_W-1:0] symbol_ticks_q;
	logic [rbtd_pkg::TICK_W-1:0] switch_ticks_q;

	// Captured sample
	logic                           level_q;
	logic [rbtd_pkg::ELAPSED_W-1:0] t_q;

	// Level tracking
	logic                              dec_q;
	logic [rbtd_pkg::TICK_W-1:0]       glitch_q;
	logic signed [rbtd_pkg::DUR_W-1:0] mark_q;
	logic signed [rbtd_pkg::DUR_W-1:0] space_q;

	// Run to bits
	logic signed [rbtd_pkg::RUN_W-1:0] run_q;
	logic                              run_bit_q;
	logic                              run_active_q;
	logic [rbtd_pkg::RUN_CNT_W-1:0]    run_cnt_q;

	// Shifter and frame collection
	logic [SHIFT_WIDTH-1:0]           shifter_q;
	logic [rbtd_pkg::COUNT_W-1:0]     held_q;
	logic [rbtd_pkg::CODE_W-1:0]      codes_q [rbtd_pkg::MAX_RESULTS];
	logic [rbtd_pkg::RES_IDX_W-1:0]   code_cnt_q;
	logic [rbtd_pkg::RES_IDX_W-1:0]   emit_idx_q;

	// Output register
	logic                        out_valid_q;
	logic [rbtd_pkg::CODE_W-1:0] out_code_q;
	logic                        out_last_q;

	// Update arithmetic
	logic                                differ;
	logic [rbtd_pkg::GSUM_W-1:0]         gsum;
	logic                                close_run;
	logic signed [rbtd_pkg::DUR_W:0]     dur_a;
	logic signed [rbtd_pkg::DUR_W:0]     dur_b;
	logic signed [rbtd_pkg::DUR_W:0]     dur_sum;
	logic signed [rbtd_pkg::DUR_W-1:0]   dur_sat;
	logic signed [rbtd_pkg::DUR_W-1:0]   new_run_dur;

	// Bit generation and framing
	logic signed [rbtd_pkg::RUN_W-1:0]   half_sym;
	logic [rbtd_pkg::COUNT_W-1:0]        over;
	logic [EXT_W-1:0]                    ext;
	logic [EXT_W-1:0]                    ext_sh;
	logic [rbtd_pkg::FRAME_BITS-1:0]     win;
	logic                                frame_ok;
	logic [rbtd_pkg::CODE_W-1:0]         rev_code;

	assign differ    = (level_q != dec_q);
	assign gsum      = rbtd_pkg::GSUM_W'(glitch_q) + rbtd_pkg::GSUM_W'(t_q);
	assign close_run = differ && (gsum > rbtd_pkg::GSUM_W'(switch_ticks_q));

	// The duration of the level now held either closes (the disagreeing
	// ticks are taken back from it) or grows by the elapsed ticks.
	always_comb begin
		dur_a = dec_q ? (rbtd_pkg::DUR_W+1)'(mark_q) : (rbtd_pkg::DUR_W+1)'(space_q);
		dur_a = dec_q ? {mark_q[rbtd_pkg::DUR_W-1], mark_q}
		              : {space_q[rbtd_pkg::DUR_W-1], space_q};
		if (close_run) begin
			dur_b = -$signed({{(rbtd_pkg::DUR_W+1-rbtd_pkg::TICK_W){1'b0}}, glitch_q});
		end else begin
			dur_b = $signed({{(rbtd_pkg::DUR_W+1-rbtd_pkg::ELAPSED_W){1'b0}}, t_q});
		end
		dur_sum = dur_a + dur_b;
		if (dur_sum[rbtd_pkg::DUR_W] != dur_sum[rbtd_pkg::DUR_W-1]) begin
			dur_sat = dur_sum[rbtd_pkg::DUR_W] ? {1'b1, {(rbtd_pkg::DUR_W-1){1'b0}}}
			                                   : {1'b0, {(rbtd_pkg::DUR_W-1){1'b1}}};
		end else begin
			dur_sat = dur_sum[rbtd_pkg::DUR_W-1:0];
		end
		new_run_dur = $signed(rbtd_pkg::DUR_W'(glitch_q) + rbtd_pkg::DUR_W'(t_q));
	end

	assign half_sym = $signed({{(rbtd_pkg::RUN_W-rbtd_pkg::TICK_W+1){1'b0}},
	                           symbol_ticks_q[rbtd_pkg::TICK_W-1:1]});

	// Bits above the shifter read as zero once more bits are counted than held.
	assign over     = held_q - rbtd_pkg::COUNT_W'(rbtd_pkg::FRAME_BITS);
	assign ext      = EXT_W'(shifter_q);
	assign ext_sh   = ext >> over;
	assign win      = ext_sh[rbtd_pkg::FRAME_BITS-1:0];
	assign frame_ok = win[rbtd_pkg::STOP_BIT_LO] && win[rbtd_pkg::STOP_BIT_HI]
	                  && !win[rbtd_pkg::START_BIT];

	always_comb begin
		for (int i = 0; i < rbtd_pkg::CODE_W; i++) begin
			rev_code[rbtd_pkg::CODE_W-1-i] = win[rbtd_pkg::CODE_LSB+i];
		end
	end

	assign status.run_more   = run_active_q && (run_q > half_sym)
	                           && (run_cnt_q < rbtd_pkg::RUN_CNT_W'(rbtd_pkg::MAX_RUN_BITS));
	assign status.frame_more = (held_q >= rbtd_pkg::COUNT_W'(rbtd_pkg::FRAME_BITS));
	assign status.have_codes = (code_cnt_q != '0);
	assign status.emit_last  = (emit_idx_q == code_cnt_q - 1'b1);
	assign status.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_ticks_q <= rbtd_pkg::SYMBOL_TICKS_RESET;
			switch_ticks_q <= rbtd_pkg::SWITCH_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbtd_pkg::REG_SYMBOL_TICKS: symbol_ticks_q <= cfg_data;
				rbtd_pkg::REG_SWITCH_TICKS: switch_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= ~s_tdata[0];
			t_q     <= s_tdata[rbtd_pkg::ELAPSED_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q        <= 1'b1;
			glitch_q     <= '0;
			mark_q       <= '0;
			space_q      <= '0;
			run_q        <= '0;
			run_bit_q    <= 1'b0;
			run_active_q <= 1'b0;
			run_cnt_q    <= '0;
			shifter_q    <= '0;
			held_q       <= '0;
			code_cnt_q   <= '0;
		end else begin
			if (cmd.capture) begin
				code_cnt_q <= '0;
			end
			if (cmd.update) begin
				run_cnt_q <= '0;
				if (close_run) begin
					// The closing run is loaded with its duration; each bit taken from it subtracts one symbol.
					run_q        <= {{2{dur_sat[rbtd_pkg::DUR_W-1]}}, dur_sat};
					run_bit_q    <= dec_q;
					run_active_q <= 1'b1;
					dec_q        <= level_q;
					glitch_q     <= '0;
					if (dec_q) begin
						mark_q  <= '0;
						space_q <= new_run_dur;
					end else begin
						space_q <= '0;
						mark_q  <= new_run_dur;
					end
				end else begin
					run_active_q <= 1'b0;
					glitch_q     <= differ ? gsum[rbtd_pkg::TICK_W-1:0] : '0;
					if (dec_q) begin
						mark_q <= dur_sat;
					end else begin
						space_q <= dur_sat;
					end
				end
			end
			if (cmd.bit_step) begin
				shifter_q <= {shifter_q[SHIFT_WIDTH-2:0], run_bit_q};
				run_q     <= run_q - $signed({{(rbtd_pkg::RUN_W-rbtd_pkg::TICK_W){1'b0}},
				                              symbol_ticks_q});
				run_cnt_q <= run_cnt_q + 1'b1;
				if (held_q != rbtd_pkg::COUNT_W'(rbtd_pkg::COUNT_MAX)) begin
					held_q <= held_q + 1'b1;
				end
			end
			if (cmd.frame_step) begin
				if (frame_ok && (code_cnt_q < rbtd_pkg::RES_IDX_W'(rbtd_pkg::MAX_RESULTS))) begin
					code_cnt_q <= code_cnt_q + 1'b1;
					held_q     <= held_q - rbtd_pkg::COUNT_W'(rbtd_pkg::FRAME_BITS);
				end else begin
					held_q <= held_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_step && frame_ok
		    && (code_cnt_q < rbtd_pkg::RES_IDX_W'(rbtd_pkg::MAX_RESULTS))) begin
			codes_q[code_cnt_q] <= rev_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_load) begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_code_q <= codes_q[emit_idx_q];
			out_last_q <= status.emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rbtd_pkg::OUT_TDATA_W'(out_code_q);
	assign m_tlast  = out_last_q;

endmodule

// ----- sv/rtty_bit_timing_deframer.sv -----
// ----------------------------------------------------------------------------
// rtty_bit_timing_deframer
// Bit timing recovery and character deframing for a 45.45 baud RTTY receiver.
// ----------------------------------------------------------------------------
// Input stream: one request per discriminator sample, carrying the space/mark
// sign and the ticks elapsed since the previous sample. Output stream: zero to
// three Baudot codes per input request; tlast marks the last code of a request.
// Configuration: symbol_ticks (index 0) and switch_ticks (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block does not enforce; other indices are ignored.
// One request at a time is processed: capture (on acceptance), level update,
// bit generation (up to 32 bits), deframing (up to 24 steps) and delivery of
// each code.
// The last code waits in the output register while the next input request is
// accepted; a stalled receiver holds the sequencer in the delivery state.
// Reset returns the configuration to 1375/343 ticks, the decoded level to
// mark and clears the durations, shifter and bit count.
// ----------------------------------------------------------------------------
module rtty_bit_timing_deframer #(
	parameter int SHIFT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rbtd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbtd_pkg::TICK_W-1:0]       cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rbtd_pkg::IN_TDATA_W-1:0]   s_tdata,  // space_sample, elapsed_ticks[15:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbtd_pkg::OUT_TDATA_W-1:0]  m_tdata,  // baudot_code[4:0]
	output logic                              m_tlast
);

	rbtd_pkg::cmd_t    cmd;
	rbtd_pkg::status_t status;

	rbtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rbtd_dp #(
		.SHIFT_WIDTH (SHIFT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
